@@ src/rgbdith_pkg.sv @@
// Shared types and constants of the RGB565 error diffusion ditherer.
`timescale 1ns / 1ps

package rgbdith_pkg;

  // Channel order inside per-channel arrays.
  localparam int unsigned ChanRed   = 0;
  localparam int unsigned ChanGreen = 1;
  localparam int unsigned ChanBlue  = 2;
  localparam int unsigned NumChan   = 3;

  // Bits kept per channel in the RGB565 word.
  localparam int unsigned RedBits   = 5;
  localparam int unsigned GreenBits = 6;
  localparam int unsigned BlueBits  = 5;

  // Configuration register width and reset value.
  localparam int unsigned CfgWidthW = 10;
  localparam logic [CfgWidthW-1:0] CfgWidthReset = 10'd480;

  // Quantization error of one channel (at most three dropped bits).
  typedef logic [2:0] qerr_t;

  // Sixteenths owed to one channel of the row below (at most 63).
  typedef logic [5:0] share_t;

  // One line buffer entry: the three channel shares.
  typedef share_t [NumChan-1:0] entry_t;

  // Mask of the dropped bits per channel.
  localparam qerr_t ErrMask [NumChan] = '{3'b111, 3'b011, 3'b111};

endpackage

@@ src/rgb565_error_diffusion_dither_core.sv @@
// Top level of the RGB888 to RGB565 Floyd-Steinberg ditherer.
// Pipeline: an accepted request is registered into stage 1 together with its
//   registered line buffer read, and its result enters the output register
//   when stage 1 hands it on.
// Throughput: one pixel per cycle, back to back, while the output is not stalled.
//   The single line buffer write port never holds the input: a row end defers one write into the next idle slot.
// Reset: control state, carries and counters clear, image width reads 480;
//   the line buffer is not cleared and its contents are only used after they were written.
`timescale 1ns / 1ps

module rgb565_error_diffusion_dither_core
  import rgbdith_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 512
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // width register write
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgWidthW-1:0] cfg_data_i,
  // source pixels
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           red_in_i,
  input  logic [7:0]           green_in_i,
  input  logic [7:0]           blue_in_i,
  input  logic                 frame_start_i,
  // dithered pixels
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [15:0]          pixel_out_o,
  output logic                 row_end_o
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned WW = (CW > CfgWidthW) ? CW : CfgWidthW;

  // ------------------------------------------------------------------
  // Configuration: a single register, always ready.
  // ------------------------------------------------------------------
  logic [CfgWidthW-1:0] image_width_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q <= CfgWidthReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      image_width_q <= cfg_data_i;
    end
  end

  // Clamp the width: zero acts as one, anything above the buffer as full.
  logic [WW-1:0] width_ext;
  logic [CW-1:0] width_eff;
  logic [AW-1:0] width_m1;

  always_comb begin
    width_ext = WW'(image_width_q);
    if (width_ext == '0) begin
      width_eff = CW'(1);
    end else if (width_ext > WW'(MAX_WIDTH)) begin
      width_eff = CW'(MAX_WIDTH);
    end else begin
      width_eff = CW'(width_ext);
    end
    width_m1 = AW'(width_eff - CW'(1));
  end

  // ------------------------------------------------------------------
  // Stage 0: accept, track the column, issue the line buffer read.
  // ------------------------------------------------------------------
  logic          s1_valid_q;
  logic          s1_fire;
  logic          in_accept;
  logic [AW-1:0] column_count_q;
  logic          in_first_row_q;
  logic [AW-1:0] acc_cc;
  logic [AW-1:0] acc_col;
  logic          acc_last;
  logic          acc_first;

  // Stage 1 may take a new request when empty or when it hands its result on.
  assign in_stall_o = s1_valid_q && !s1_fire;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    acc_cc    = frame_start_i ? '0 : column_count_q;
    acc_first = frame_start_i ? 1'b1 : in_first_row_q;
    // A width lowered mid-row ends the row on the current pixel.
    acc_last  = (acc_cc >= width_m1);
    acc_col   = acc_last ? width_m1 : acc_cc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_count_q <= '0;
      in_first_row_q <= 1'b1;
    end else if (in_accept) begin
      if (acc_last) begin
        column_count_q <= '0;
        in_first_row_q <= 1'b0;
      end else begin
        column_count_q <= acc_col + AW'(1);
        in_first_row_q <= acc_first;
      end
    end
  end

  // ------------------------------------------------------------------
  // Line buffer: shares owed to the next row, one entry per column.
  // One write port, one registered read port.
  // ------------------------------------------------------------------
  entry_t        line_mem_q [MAX_WIDTH];
  entry_t        rdata_q;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      line_mem_q[wr_addr] <= wr_data;
    end
    if (in_accept) begin
      rdata_q <= line_mem_q[acc_col];
    end
  end

  // Deferred write: at a row end the last column's entry waits for a free port
  // because the entry below-left takes the port.
  logic          pend_valid_q;
  logic [AW-1:0] pend_addr_q;
  entry_t        pend_data_q;

  // Forward a write that lands on the entry being read, or one still pending.
  logic          fwd_hit_d;
  entry_t        fwd_data_d;
  logic          fwd_hit_q;
  entry_t        fwd_data_q;

  always_comb begin
    fwd_hit_d  = 1'b0;
    fwd_data_d = pend_data_q;
    if (wr_en && (wr_addr == acc_col)) begin
      fwd_hit_d  = 1'b1;
      fwd_data_d = wr_data;
    end else if (pend_valid_q && (pend_addr_q == acc_col)) begin
      fwd_hit_d  = 1'b1;
    end
  end

  // ------------------------------------------------------------------
  // Stage 1 registers.
  // ------------------------------------------------------------------
  logic [7:0]    s1_pix_q [NumChan];
  logic          s1_fs_q;
  logic          s1_first_q;
  logic          s1_last_q;
  logic [AW-1:0] s1_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_pix_q[ChanRed]   <= red_in_i;
      s1_pix_q[ChanGreen] <= green_in_i;
      s1_pix_q[ChanBlue]  <= blue_in_i;
      s1_fs_q             <= frame_start_i;
      s1_first_q          <= acc_first;
      s1_last_q           <= acc_last;
      s1_col_q            <= acc_col;
      fwd_hit_q           <= fwd_hit_d;
      fwd_data_q          <= fwd_data_d;
    end
  end

  // ------------------------------------------------------------------
  // Stage 1: diffuse, quantize, spread the error.
  // ------------------------------------------------------------------
  logic   out_valid_q;
  share_t right_carry_q [NumChan];
  qerr_t  last_err_q    [NumChan];
  qerr_t  second_err_q  [NumChan];

  entry_t nre;
  share_t rc_eff        [NumChan];
  qerr_t  le_eff        [NumChan];
  qerr_t  sle_eff       [NumChan];
  logic [6:0] diff      [NumChan];
  logic [7:0] diff_rnd  [NumChan];
  logic [8:0] sum       [NumChan];
  logic [7:0] sat       [NumChan];
  qerr_t  err           [NumChan];
  entry_t below_left;
  entry_t below;
  share_t rc_next       [NumChan];

  assign s1_fire = s1_valid_q && (!out_valid_q || !out_stall_i);

  always_comb begin
    nre = fwd_hit_q ? fwd_data_q : rdata_q;
    for (int c = 0; c < NumChan; c++) begin
      // A frame start clears the row state before this pixel uses it.
      rc_eff[c]   = s1_fs_q ? '0 : right_carry_q[c];
      le_eff[c]   = s1_fs_q ? '0 : last_err_q[c];
      sle_eff[c]  = s1_fs_q ? '0 : second_err_q[c];
      diff[c]     = {1'b0, rc_eff[c]} + (s1_first_q ? 7'd0 : {1'b0, nre[c]});
      diff_rnd[c] = {1'b0, diff[c]} + 8'd8;
      sum[c]      = {1'b0, s1_pix_q[c]} + {5'b0, diff_rnd[c][7:4]};
      sat[c]      = sum[c][8] ? 8'hFF : sum[c][7:0];
      err[c]      = sat[c][2:0] & ErrMask[c];
      below_left[c] = {3'b0, sle_eff[c]} + ({3'b0, le_eff[c]} * 6'd5)
                    + ({3'b0, err[c]} * 6'd3);
      below[c]      = {3'b0, le_eff[c]} + ({3'b0, err[c]} * 6'd5);
      rc_next[c]    = {3'b0, err[c]} * 6'd7;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NumChan; c++) begin
        right_carry_q[c] <= '0;
        last_err_q[c]    <= '0;
        second_err_q[c]  <= '0;
      end
    end else if (s1_fire) begin
      for (int c = 0; c < NumChan; c++) begin
        if (s1_last_q) begin
          right_carry_q[c] <= '0;
          last_err_q[c]    <= '0;
          second_err_q[c]  <= '0;
        end else begin
          right_carry_q[c] <= rc_next[c];
          last_err_q[c]    <= err[c];
          second_err_q[c]  <= le_eff[c];
        end
      end
    end
  end

  // Write port: the pixel's own write first, the deferred entry when free.
  logic          pix_wr_en;
  logic [AW-1:0] pix_wr_addr;
  entry_t        pix_wr_data;
  logic          new_pend;

  always_comb begin
    pix_wr_en   = s1_fire && ((s1_col_q != '0) || s1_last_q);
    pix_wr_addr = (s1_col_q != '0) ? (s1_col_q - AW'(1)) : s1_col_q;
    pix_wr_data = (s1_col_q != '0) ? below_left : below;
    new_pend    = s1_fire && s1_last_q && (s1_col_q != '0);
    wr_en       = pix_wr_en || pend_valid_q;
    wr_addr     = pix_wr_en ? pix_wr_addr : pend_addr_q;
    wr_data     = pix_wr_en ? pix_wr_data : pend_data_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else if (new_pend) begin
      pend_valid_q <= 1'b1;
    end else if (pix_wr_en) begin
      // Drop a pending entry that a newer write has replaced.
      pend_valid_q <= pend_valid_q && (pix_wr_addr != pend_addr_q);
    end else begin
      pend_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (new_pend) begin
      pend_addr_q <= s1_col_q;
      pend_data_q <= below;
    end
  end

  // ------------------------------------------------------------------
  // Output register.
  // ------------------------------------------------------------------
  logic [15:0] pixel_q;
  logic        row_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= s1_fire || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      pixel_q   <= {sat[ChanRed][7 -: RedBits],
                    sat[ChanGreen][7 -: GreenBits],
                    sat[ChanBlue][7 -: BlueBits]};
      row_end_q <= s1_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_out_o = pixel_q;
  assign row_end_o   = row_end_q;

  // ------------------------------------------------------------------
  // Assertions.
  // ------------------------------------------------------------------
  a_accept_fills_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> s1_valid_q)
    else $error("accepted request did not reach stage 1");

  a_fire_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> out_valid_q)
    else $error("stage 1 result did not reach the output register");

  a_pending_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q && !pix_wr_en |=> !pend_valid_q)
    else $error("deferred line buffer write not retired on a free port");

  a_column_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && !acc_last |=> column_count_q != '0)
    else $error("column counter did not advance inside a row");

endmodule
